### src/sparse_penalty_evaluator_unit_assert.svh
// assertion macros for the sparse penalty evaluator
`ifndef SPARSE_PENALTY_EVALUATOR_UNIT_ASSERT_SVH
`define SPARSE_PENALTY_EVALUATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPE_ASSERT_IMP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define SPE_ASSERT_IMP(lbl, clk, rst, prop, msg)
`define SPE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/spe_pkg.sv
// shared types and constants of the sparse penalty evaluator
`default_nettype none
package spe_pkg;
   localparam int CFG_W     = 32;
   localparam int RES_W     = 48;
   localparam int PROD_W    = 64;
   localparam int GS_W      = 33;
   localparam int LLGS_W    = 97;
   localparam int LLG_W     = 96;
   localparam int CSR_IDX_W = 4;
   localparam int CHUNK_W   = 16;
   localparam int DIV_STEPS = 4;
   localparam int SETTLE_W  = 2;

   localparam logic [SETTLE_W-1:0] SETTLE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_KIND   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAMBDA = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAMMA  = 4'd3;

   localparam logic [1:0] KIND_LASSO = 2'd0;
   localparam logic [1:0] KIND_SCAD  = 2'd1;
   localparam logic [1:0] KIND_MCP   = 2'd2;

   localparam logic [CFG_W-1:0] LAMBDA_RESET = 32'd65536;
   localparam logic [CFG_W-1:0] GAMMA_RESET  = 32'd242483;

   typedef struct packed {
      logic [1:0]        kind;
      logic              deriv;
      logic [CFG_W-1:0]  lam;
      logic [CFG_W-1:0]  gam;
      logic [CFG_W-1:0]  gd;
      logic [PROD_W-1:0] lg;
      logic [PROD_W-1:0] ll;
      logic [LLGS_W-1:0] llgs;
      logic [LLG_W-1:0]  llg;
      logic              scad_bad;
      logic              mcp_bad;
   } spe_cfg_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction
endpackage
`default_nettype wire

### src/spe_cfg.sv
// control registers and the lambda/gamma products derived from them
`default_nettype none
module spe_cfg #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spe_pkg::CFG_W-1:0]     csr_data,
   output logic                          busy,
   output spe_pkg::spe_cfg_type          cfg
);
   import spe_pkg::*;

   localparam logic [GS_W-1:0] S_ONE = GS_W'(1) << FRAC_BITS;

   logic [1:0]          kind_r_ff;
   logic                deriv_ff;
   logic [CFG_W-1:0]    lam_ff, gam_ff;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic                wr;

   logic [PROD_W-1:0]   lg_ff, lg_in, ll_ff, ll_in;
   logic [CFG_W-1:0]    gd_ff, gd_in;
   logic [GS_W-1:0]     gs_ff, gs_in, gam_x;
   logic                sbad_ff, mbad_ff;
   logic [CFG_W+GS_W-1:0] llgs_lo_ff, llgs_hi_ff;
   logic [PROD_W-1:0]   llg_lo_ff, llg_hi_ff;
   logic [LLGS_W-1:0]   llgs_ff, llgs_in;
   logic [LLG_W-1:0]    llg_ff, llg_in;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign busy      = (settle_ff != '0);

   always_comb begin
      if (wr) begin
         settle_in = SETTLE;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_r_ff <= KIND_LASSO;
         deriv_ff  <= 1'b0;
         lam_ff    <= LAMBDA_RESET;
         gam_ff    <= GAMMA_RESET;
         settle_ff <= SETTLE;
      end else begin
         settle_ff <= settle_in;
         if (wr) begin
            unique case (csr_index)
               REG_KIND:   kind_r_ff <= csr_data[1:0];
               REG_DERIV:  deriv_ff  <= csr_data[0];
               REG_LAMBDA: lam_ff    <= csr_data;
               REG_GAMMA:  gam_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // first stage: lambda*gamma, lambda^2, |gamma - 1|, gamma + 1
   always_comb begin
      gam_x = GS_W'(gam_ff);
      lg_in = PROD_W'(lam_ff) * PROD_W'(gam_ff);
      ll_in = PROD_W'(lam_ff) * PROD_W'(lam_ff);
      gd_in = CFG_W'((gam_x > S_ONE) ? (gam_x - S_ONE) : (S_ONE - gam_x));
      gs_in = gam_x + S_ONE;
   end

   // second stage: halves of lambda^2 times gamma and gamma+1, third stage: combine
   always_comb begin
      llgs_in = LLGS_W'(llgs_lo_ff) + (LLGS_W'(llgs_hi_ff) << CFG_W);
      llg_in  = LLG_W'(llg_lo_ff) + (LLG_W'(llg_hi_ff) << CFG_W);
   end

   always_ff @(posedge clock) begin
      lg_ff      <= lg_in;
      ll_ff      <= ll_in;
      gd_ff      <= gd_in;
      gs_ff      <= gs_in;
      sbad_ff    <= (gam_x == S_ONE);
      mbad_ff    <= (gam_ff == '0);
      llgs_lo_ff <= (CFG_W+GS_W)'(ll_ff[CFG_W-1:0]) * (CFG_W+GS_W)'(gs_ff);
      llgs_hi_ff <= (CFG_W+GS_W)'(ll_ff[PROD_W-1:CFG_W]) * (CFG_W+GS_W)'(gs_ff);
      llg_lo_ff  <= PROD_W'(ll_ff[CFG_W-1:0]) * PROD_W'(gam_ff);
      llg_hi_ff  <= PROD_W'(ll_ff[PROD_W-1:CFG_W]) * PROD_W'(gam_ff);
      llgs_ff    <= llgs_in;
      llg_ff     <= llg_in;
   end

   always_comb begin
      cfg.kind     = kind_r_ff;
      cfg.deriv    = deriv_ff;
      cfg.lam      = lam_ff;
      cfg.gam      = gam_ff;
      cfg.gd       = gd_ff;
      cfg.lg       = lg_ff;
      cfg.ll       = ll_ff;
      cfg.llgs     = llgs_ff;
      cfg.llg      = llg_ff;
      cfg.scad_bad = sbad_ff;
      cfg.mcp_bad  = mbad_ff;
   end
endmodule
`default_nettype wire

### src/spe_front.sv
// front pipeline: magnitude, products, region tests and numerator selection
`default_nettype none
module spe_front #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int NUM_W      = 80
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [DATA_WIDTH-1:0]     in_coef,
   input  spe_pkg::spe_cfg_type      cfg,
   output logic                      div_valid,
   output logic [NUM_W-1:0]          div_num,
   output logic [spe_pkg::CFG_W-1:0] div_den,
   output logic                      div_neg,
   output logic                      div_bad
);
   import spe_pkg::*;

   localparam int AW       = DATA_WIDTH;
   localparam int NCH      = (AW + CHUNK_W - 1) / CHUNK_W;
   localparam int AXP_W    = NCH * CHUNK_W;
   localparam int XS_W     = AW + FRAC_BITS;
   localparam int CW       = max_int(XS_W, PROD_W);
   localparam int LCW      = max_int(AW, CFG_W);
   localparam int LA_W     = CFG_W + AW;
   localparam int LGA_W    = PROD_W + AW;
   localparam int AA_W     = 2 * AW;
   localparam int LA_PP_W  = CFG_W + CHUNK_W;
   localparam int LGA_PP_W = PROD_W + CHUNK_W;
   localparam int AA_PP_W  = AW + CHUNK_W;
   localparam int MW       = max_int(LGA_W + 1, max_int(AA_W, PROD_W) + FRAC_BITS + 1);

   // stage a
   logic            a_vld_ff;
   logic [AW-1:0]   a_raw_ff;
   // stage b
   logic            b_vld_ff, b_neg_ff;
   logic [AW-1:0]   b_ax_ff, b_ax_in;
   // stage c
   logic            c_vld_ff, c_neg_ff, c_gt_ff, c_lt_ff, c_gel_ff;
   logic [CW-1:0]   c_dnum_ff;
   logic [LA_PP_W-1:0]  la_pp_ff  [NCH];
   logic [LA_PP_W-1:0]  la_pp_in  [NCH];
   logic [LGA_PP_W-1:0] lga_pp_ff [NCH];
   logic [LGA_PP_W-1:0] lga_pp_in [NCH];
   logic [AA_PP_W-1:0]  aa_pp_ff  [NCH];
   logic [AA_PP_W-1:0]  aa_pp_in  [NCH];
   logic [AXP_W-1:0]    axp;
   logic [CW-1:0]       xs_c, lg_c, c_dnum_in;
   // stage d
   logic            d_vld_ff, d_neg_ff, d_gt_ff, d_lt_ff, d_gel_ff;
   logic [CW-1:0]   d_dnum_ff;
   logic [LA_W-1:0] d_la_ff, d_la_in;
   logic [LGA_W-1:0] d_lga_ff, d_lga_in;
   logic [AA_W-1:0] d_aa_ff, d_aa_in;
   logic [CFG_W+AXP_W-1:0]  la_acc;
   logic [PROD_W+AXP_W-1:0] lga_acc;
   logic [AW+AXP_W-1:0]     aa_acc;
   // stage e
   logic            e_vld_ff, e_neg_ff, e_gt_ff, e_lt_ff, e_gel_ff;
   logic [CW-1:0]   e_dnum_ff;
   logic [LA_W-1:0] e_la_ff;
   logic [MW-1:0]   e_num2_ff, e_num2_in, e_subs_ff, e_subs_in, e_subm_ff, e_subm_in;
   // output stage
   logic            o_vld_ff, o_neg_ff, o_neg_in, o_bad_ff, o_bad_in;
   logic [NUM_W-1:0] o_num_ff, o_num_in;
   logic [CFG_W-1:0] o_den_ff, o_den_in;
   logic [MW-1:0]   mid_s, mid_m;
   logic            scad_outer, scad_mid, mcp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
      end
      a_raw_ff <= in_coef;
   end

   assign b_ax_in = a_raw_ff[AW-1] ? (~a_raw_ff + 1'b1) : a_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_neg_ff <= a_raw_ff[AW-1];
      b_ax_ff  <= b_ax_in;
   end

   // partial products on 16-bit slices of |x|
   always_comb begin
      axp = AXP_W'(b_ax_ff);
      for (int k = 0; k < NCH; k++) begin
         la_pp_in[k]  = LA_PP_W'(cfg.lam) * LA_PP_W'(axp[k*CHUNK_W +: CHUNK_W]);
         lga_pp_in[k] = LGA_PP_W'(cfg.lg) * LGA_PP_W'(axp[k*CHUNK_W +: CHUNK_W]);
         aa_pp_in[k]  = AA_PP_W'(b_ax_ff) * AA_PP_W'(axp[k*CHUNK_W +: CHUNK_W]);
      end
      xs_c      = CW'(b_ax_ff) << FRAC_BITS;
      lg_c      = CW'(cfg.lg);
      c_dnum_in = (lg_c > xs_c) ? (lg_c - xs_c) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_neg_ff  <= b_neg_ff;
      c_gt_ff   <= xs_c > lg_c;
      c_lt_ff   <= xs_c < lg_c;
      c_gel_ff  <= LCW'(b_ax_ff) >= LCW'(cfg.lam);
      c_dnum_ff <= c_dnum_in;
      for (int k = 0; k < NCH; k++) begin
         la_pp_ff[k]  <= la_pp_in[k];
         lga_pp_ff[k] <= lga_pp_in[k];
         aa_pp_ff[k]  <= aa_pp_in[k];
      end
   end

   always_comb begin
      la_acc  = '0;
      lga_acc = '0;
      aa_acc  = '0;
      for (int k = 0; k < NCH; k++) begin
         la_acc  = la_acc + ((CFG_W+AXP_W)'(la_pp_ff[k]) << (k*CHUNK_W));
         lga_acc = lga_acc + ((PROD_W+AXP_W)'(lga_pp_ff[k]) << (k*CHUNK_W));
         aa_acc  = aa_acc + ((AW+AXP_W)'(aa_pp_ff[k]) << (k*CHUNK_W));
      end
      d_la_in  = LA_W'(la_acc);
      d_lga_in = LGA_W'(lga_acc);
      d_aa_in  = AA_W'(aa_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
      d_neg_ff  <= c_neg_ff;
      d_gt_ff   <= c_gt_ff;
      d_lt_ff   <= c_lt_ff;
      d_gel_ff  <= c_gel_ff;
      d_dnum_ff <= c_dnum_ff;
      d_la_ff   <= d_la_in;
      d_lga_ff  <= d_lga_in;
      d_aa_ff   <= d_aa_in;
   end

   always_comb begin
      e_num2_in = MW'(d_lga_ff) << 1;
      e_subm_in = MW'(d_aa_ff) << FRAC_BITS;
      e_subs_in = (MW'(d_aa_ff) << FRAC_BITS) + (MW'(cfg.ll) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      e_neg_ff  <= d_neg_ff;
      e_gt_ff   <= d_gt_ff;
      e_lt_ff   <= d_lt_ff;
      e_gel_ff  <= d_gel_ff;
      e_dnum_ff <= d_dnum_ff;
      e_la_ff   <= d_la_ff;
      e_num2_ff <= e_num2_in;
      e_subs_ff <= e_subs_in;
      e_subm_ff <= e_subm_in;
   end

   // region decode and divider operands
   always_comb begin
      mid_s      = (e_num2_ff >= e_subs_ff) ? (e_num2_ff - e_subs_ff) : '0;
      mid_m      = (e_num2_ff >= e_subm_ff) ? (e_num2_ff - e_subm_ff) : '0;
      scad_outer = e_neg_ff ? (e_gel_ff && !e_lt_ff) : e_gt_ff;
      scad_mid   = e_neg_ff ? (e_gel_ff && e_lt_ff) : (!e_gt_ff && e_gel_ff);
      mcp_in     = e_neg_ff ? e_lt_ff : !e_gt_ff;
      o_num_in   = '0;
      o_den_in   = CFG_W'(1);
      o_neg_in   = 1'b0;
      o_bad_in   = 1'b0;
      unique case (cfg.kind)
         KIND_LASSO: begin
            if (cfg.deriv) begin
               o_num_in = NUM_W'(cfg.lam);
               o_neg_in = e_neg_ff;
            end else begin
               o_num_in = NUM_W'(e_la_ff >> FRAC_BITS);
            end
         end
         KIND_SCAD: begin
            if (cfg.scad_bad) begin
               o_bad_in = 1'b1;
            end else if (cfg.deriv) begin
               o_neg_in = e_neg_ff;
               if (scad_outer) begin
                  o_num_in = '0;
               end else if (scad_mid) begin
                  o_num_in = NUM_W'(e_dnum_ff);
                  o_den_in = cfg.gd;
               end else begin
                  o_num_in = NUM_W'(cfg.lam);
               end
            end else if (scad_outer) begin
               o_num_in = NUM_W'(cfg.llgs >> (2*FRAC_BITS + 1));
            end else if (scad_mid) begin
               o_num_in = NUM_W'(mid_s >> (FRAC_BITS + 1));
               o_den_in = cfg.gd;
            end else begin
               o_num_in = NUM_W'(e_la_ff >> FRAC_BITS);
            end
         end
         KIND_MCP: begin
            if (cfg.mcp_bad) begin
               o_bad_in = 1'b1;
            end else if (cfg.deriv) begin
               o_neg_in = e_neg_ff;
               if (mcp_in) begin
                  o_num_in = NUM_W'(e_dnum_ff);
                  o_den_in = cfg.gam;
               end
            end else if (mcp_in) begin
               o_num_in = NUM_W'(mid_m >> (FRAC_BITS + 1));
               o_den_in = cfg.gam;
            end else begin
               o_num_in = NUM_W'(cfg.llg >> (2*FRAC_BITS + 1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= e_vld_ff;
      end
      o_num_ff <= o_num_in;
      o_den_ff <= o_den_in;
      o_neg_ff <= o_neg_in;
      o_bad_ff <= o_bad_in;
   end

   assign div_valid = o_vld_ff;
   assign div_num   = o_num_ff;
   assign div_den   = o_den_ff;
   assign div_neg   = o_neg_ff;
   assign div_bad   = o_bad_ff;
endmodule
`default_nettype wire

### src/spe_div.sv
// pipelined restoring divider, four quotient bits per stage
`default_nettype none
module spe_div #(
   parameter int NUM_W = 80
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [NUM_W-1:0]          in_num,
   input  logic [spe_pkg::CFG_W-1:0] in_den,
   input  logic                      in_neg,
   input  logic                      in_bad,
   output logic                      out_valid,
   output logic [NUM_W-1:0]          out_quo,
   output logic                      out_neg,
   output logic                      out_bad
);
   import spe_pkg::*;

   localparam int NST = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

   logic             vld_ff [NST];
   logic [NUM_W-1:0] nq_ff  [NST];
   logic [NUM_W-1:0] nq_in  [NST];
   logic [CFG_W-1:0] rem_ff [NST];
   logic [CFG_W-1:0] rem_in [NST];
   logic [CFG_W-1:0] den_ff [NST];
   logic             neg_ff [NST];
   logic             bad_ff [NST];
   logic             vld_src [NST];
   logic [CFG_W-1:0] den_src [NST];
   logic             neg_src [NST];
   logic             bad_src [NST];

   // nq holds the numerator bits still to shift out and the quotient bits shifted in
   always_comb begin : p_steps
      logic [CFG_W:0]   t;
      logic [CFG_W-1:0] r;
      logic [NUM_W-1:0] q;
      for (int k = 0; k < NST; k++) begin
         if (k == 0) begin
            vld_src[k] = in_valid;
            den_src[k] = in_den;
            neg_src[k] = in_neg;
            bad_src[k] = in_bad;
            q          = in_num;
            r          = '0;
         end else begin
            vld_src[k] = vld_ff[k-1];
            den_src[k] = den_ff[k-1];
            neg_src[k] = neg_ff[k-1];
            bad_src[k] = bad_ff[k-1];
            q          = nq_ff[k-1];
            r          = rem_ff[k-1];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (k*DIV_STEPS + j < NUM_W) begin
               t = {r, q[NUM_W-1]};
               q = q << 1;
               if (t >= {1'b0, den_src[k]}) begin
                  t    = t - {1'b0, den_src[k]};
                  q[0] = 1'b1;
               end
               r = t[CFG_W-1:0];
            end
         end
         nq_in[k]  = q;
         rem_in[k] = r;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src[k];
         end
         nq_ff[k]  <= nq_in[k];
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_src[k];
         neg_ff[k] <= neg_src[k];
         bad_ff[k] <= bad_src[k];
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_quo   = nq_ff[NST-1];
   assign out_neg   = neg_ff[NST-1];
   assign out_bad   = bad_ff[NST-1];
endmodule
`default_nettype wire

### src/sparse_penalty_evaluator_unit.sv
// top level of the lasso / scad / mcp penalty evaluator
// path of a start: front stages a-e, front output stage, divider stages, result register
// throughput: one word per cycle while not busy; divider fully pipelined, four quotient bits a stage
// busy is set by reset and by every csr write and held while the lambda/gamma products settle
// reset is synchronous and clears control state; results cannot be held off
`default_nettype none
`include "sparse_penalty_evaluator_unit_assert.svh"
module sparse_penalty_evaluator_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [DATA_WIDTH-1:0]  req_coefficient,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spe_pkg::CFG_W-1:0]     csr_data,
   output logic                          rsp_valid,
   output logic signed [spe_pkg::RES_W-1:0] rsp_penalty_result,
   output logic                          rsp_bad_gamma,
   output logic                          rsp_saturated
);
   import spe_pkg::*;

   localparam int NUM_W = max_int(max_int(PROD_W + DATA_WIDTH - FRAC_BITS, PROD_W),
                                  max_int(DATA_WIDTH + FRAC_BITS, LLGS_W - 1 - 2*FRAC_BITS));
   localparam logic [NUM_W-1:0] LIM_POS = NUM_W'((64'd1 << (RES_W - 1)) - 64'd1);
   localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'd1 << (RES_W - 1));
   localparam logic [RES_W-1:0] SAT_MAX = RES_W'(LIM_POS);
   localparam logic [RES_W-1:0] SAT_MIN = RES_W'(LIM_NEG);

   spe_cfg_type      cfg;
   logic             f_valid, f_neg, f_bad;
   logic [NUM_W-1:0] f_num;
   logic [CFG_W-1:0] f_den;
   logic             q_valid, q_neg, q_bad;
   logic [NUM_W-1:0] q_quo;

   logic             neg_eff;
   logic [NUM_W-1:0] lim;
   logic [RES_W-1:0] mag;
   logic             rsp_valid_ff, rsp_bad_ff, rsp_sat_ff, rsp_sat_in;
   logic [RES_W-1:0] rsp_res_ff, rsp_res_in;

   spe_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .cfg       (cfg)
   );

   spe_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .NUM_W      (NUM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_coef   (req_coefficient),
      .cfg       (cfg),
      .div_valid (f_valid),
      .div_num   (f_num),
      .div_den   (f_den),
      .div_neg   (f_neg),
      .div_bad   (f_bad)
   );

   spe_div #(.NUM_W(NUM_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_neg    (f_neg),
      .in_bad    (f_bad),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_neg   (q_neg),
      .out_bad   (q_bad)
   );

   // sign and clip to q31.16
   always_comb begin
      neg_eff    = q_neg && (q_quo != '0);
      lim        = neg_eff ? LIM_NEG : LIM_POS;
      rsp_sat_in = q_quo > lim;
      mag        = rsp_sat_in ? RES_W'(lim) : q_quo[RES_W-1:0];
      rsp_res_in = neg_eff ? (~mag + 1'b1) : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= q_valid;
      end
      rsp_res_ff <= rsp_res_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_bad_ff <= q_bad;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_penalty_result = rsp_res_ff;
   assign rsp_bad_gamma      = rsp_bad_ff;
   assign rsp_saturated      = rsp_sat_ff;

   `SPE_ASSERT_IMP(a_bad_gives_zero, clock, reset, rsp_valid && rsp_bad_gamma |-> (rsp_penalty_result == '0) && !rsp_saturated, "bad gamma word not zero")
   `SPE_ASSERT_IMP(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated |-> (rsp_penalty_result == SAT_MAX) || (rsp_penalty_result == SAT_MIN), "clipped word off the limit")
   `SPE_ASSERT_NXT(a_csr_holds_off, clock, reset, csr_valid && csr_ready, busy, "no busy after csr write")
endmodule
`default_nettype wire

### sim/tb_sparse_penalty_evaluator_unit.sv
// testbench for the lasso / scad / mcp penalty evaluator: random and boundary checks
`timescale 1ns / 100ps
`default_nettype none
module tb_sparse_penalty_evaluator_unit;
   import spe_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam logic [127:0] ONE_S = 128'd1 << FB;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd9;

   typedef struct packed {
      logic [RES_W-1:0] value;
      logic             bad;
      logic             sat;
   } penalty_word_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [DW-1:0] req_coefficient;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   logic                 rsp_valid;
   logic signed [RES_W-1:0] rsp_penalty_result;
   logic                 rsp_bad_gamma;
   logic                 rsp_saturated;

   sparse_penalty_evaluator_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coefficient(req_coefficient),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_penalty_result(rsp_penalty_result),
      .rsp_bad_gamma(rsp_bad_gamma), .rsp_saturated(rsp_saturated)
   );

   logic [1:0]       kind_sh;
   logic             deriv_sh;
   logic [CFG_W-1:0] lam_sh;
   logic [CFG_W-1:0] gam_sh;

   logic [DW-1:0]     coef_queue[$];
   penalty_word_type  penalty_queue[$];
   int                fail_count;
   int                gap_left;
   bit                calm;

   function automatic logic [127:0] clamp_sub(input logic [127:0] a, input logic [127:0] b);
      return (a < b) ? 128'd0 : a - b;
   endfunction

   function automatic penalty_word_type penalty_of(input logic [DW-1:0] coef);
      logic [127:0] ax, xs, lg, ll, inner, mag, num, sq, lgm, gd, lim, m;
      logic [DW-1:0] axd;
      bit xneg, neg, outer, mid, in_range;
      penalty_word_type w;
      xneg = coef[DW-1];
      axd = xneg ? (~coef + 1'b1) : coef;
      ax = 128'(axd);
      xs = ax << FB;
      lg = 128'(lam_sh) * 128'(gam_sh);
      ll = 128'(lam_sh) * 128'(lam_sh);
      inner = (128'(lam_sh) * ax) >> FB;
      mag = 0;
      neg = 0;
      w = '0;
      if (kind_sh == KIND_LASSO) begin
         if (deriv_sh) begin
            mag = 128'(lam_sh);
            neg = xneg;
         end else mag = inner;
      end else if (kind_sh == KIND_SCAD) begin
         if (128'(gam_sh) == ONE_S) begin
            w.bad = 1;
            return w;
         end
         gd = (128'(gam_sh) > ONE_S) ? 128'(gam_sh) - ONE_S : ONE_S - 128'(gam_sh);
         if (!xneg) begin
            outer = xs > lg;
            mid = !outer && ax >= 128'(lam_sh);
         end else begin
            mid = ax >= 128'(lam_sh) && xs < lg;
            outer = ax >= 128'(lam_sh) && !mid;
         end
         if (deriv_sh) begin
            neg = xneg;
            if (outer) mag = 0;
            else if (mid) mag = clamp_sub(lg, xs) / gd;
            else mag = 128'(lam_sh);
         end else if (outer) begin
            mag = (ll * (128'(gam_sh) + ONE_S)) >> (2 * FB + 1);
         end else if (mid) begin
            num = (lg * ax) << 1;
            sq = ((ax * ax) << FB) + (ll << FB);
            mag = clamp_sub(num, sq) / (2 * ONE_S * gd);
         end else mag = inner;
      end else if (kind_sh == KIND_MCP) begin
         if (gam_sh == 0) begin
            w.bad = 1;
            return w;
         end
         in_range = xneg ? (xs < lg) : (xs <= lg);
         if (deriv_sh) begin
            neg = xneg;
            if (in_range) mag = clamp_sub(lg, xs) / 128'(gam_sh);
         end else if (in_range) begin
            lgm = (lg * ax) << 1;
            mag = clamp_sub(lgm, (ax * ax) << FB) / (2 * ONE_S * 128'(gam_sh));
         end else mag = (ll * 128'(gam_sh)) >> (2 * FB + 1);
      end
      if (mag == 0) neg = 0;
      lim = (128'd1 << (RES_W - 1)) - (neg ? 128'd0 : 128'd1);
      m = mag;
      if (mag > lim) begin
         m = lim;
         w.sat = 1;
      end
      w.value = neg ? RES_W'(-m) : RES_W'(m);
      return w;
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_sparse_penalty_evaluator_unit NOT OK");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_coefficient <= '0;
         gap_left <= 0;
      end else begin
         if (start && !busy) penalty_queue.push_back(penalty_of(req_coefficient));
         if (start && busy) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 0;
         end else if (coef_queue.size() > 0) begin
            req_coefficient <= coef_queue.pop_front();
            start <= 1;
            if (!calm && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 17);
         end else start <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (penalty_queue.size() == 0) begin
            $error("unexpected word: result %h", rsp_penalty_result);
            fail_count++;
         end else begin
            penalty_word_type e;
            e = penalty_queue.pop_front();
            if (rsp_penalty_result !== e.value) begin
               $error("penalty_result expected %h got %h", e.value, rsp_penalty_result);
               fail_count++;
            end
            if (rsp_bad_gamma !== e.bad) begin
               $error("bad_gamma expected %b got %b", e.bad, rsp_bad_gamma);
               fail_count++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated expected %b got %b", e.sat, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         REG_KIND:   kind_sh = val[1:0];
         REG_DERIV:  deriv_sh = val[0];
         REG_LAMBDA: lam_sh = val;
         REG_GAMMA:  gam_sh = val;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (coef_queue.size() > 0 || penalty_queue.size() > 0 || start) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [DW-1:0] random_coef;
      logic [127:0] b;
      logic [DW-1:0] v;
      b = (128'(lam_sh) * 128'(gam_sh)) >> FB;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = (b > 128'h7fff_0000) ? $urandom
                                     : DW'(b) + DW'($urandom_range(0, 4)) - DW'(2);
         2: v = lam_sh + DW'($urandom_range(0, 4)) - DW'(2);
         3: v = DW'($urandom_range(0, 3)) * (DW'(b) >> 1) + DW'($urandom_range(0, 255));
         default: v = DW'($urandom_range(0, 1 << 20));
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic run_phase(input logic [1:0] k, input logic d, input logic [CFG_W-1:0] l,
                            input logic [CFG_W-1:0] g, input int n);
      logic [DW-1:0] b;
      csr_write(REG_KIND, CFG_W'(k));
      csr_write(REG_DERIV, CFG_W'(d));
      csr_write(REG_LAMBDA, l);
      csr_write(REG_GAMMA, g);
      b = DW'((64'(l) * 64'(g)) >> FB);
      coef_queue.push_back(l);
      coef_queue.push_back(-l);
      coef_queue.push_back(b);
      coef_queue.push_back(-b);
      coef_queue.push_back(b + 1'b1);
      repeat (n) coef_queue.push_back(random_coef());
      drain();
   endtask

   initial begin
      logic [CFG_W-1:0] lams[5];
      logic [CFG_W-1:0] gams[6];
      reset = 1;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      fail_count = 0;
      calm = 0;
      kind_sh = KIND_LASSO;
      deriv_sh = 0;
      lam_sh = LAMBDA_RESET;
      gam_sh = GAMMA_RESET;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // defaults straight after reset, field extremes
      coef_queue = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h0001_0000, 32'hffff_0000, 32'h0003_b333, 32'hfffc_4ccd,
                     32'h5555_5555, 32'haaaa_aaaa};
      drain();
      csr_write(REG_UNUSED, 32'hffff_ffff);
      lams = '{32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h0000_8000, 32'h0123_4567};
      gams = '{32'h0, 32'h0001_0000, 32'hffff_ffff, 32'h0000_8000, 32'h0003_b333,
               32'h0002_0000};
      for (int k = 0; k < 4; k++)
         for (int d = 0; d < 2; d++)
            for (int j = 0; j < 6; j++) begin
               if (k == 3 && j > 1) continue;
               run_phase(2'(k), 1'(d), lams[(j + k + d) % 5], gams[j],
                         (k == 3) ? 3 : 8);
            end
      for (int r = 0; r < 8; r++) begin
         if (r == 7) calm = 1;
         run_phase(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                   (r % 2) ? $urandom : $urandom_range(0, 1 << 18),
                   (r % 3 == 0) ? $urandom : $urandom_range(0, 1 << 19), 30);
      end
      if (fail_count == 0) begin
         $display("tb_sparse_penalty_evaluator_unit OK");
      end else begin
         $display("tb_sparse_penalty_evaluator_unit NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
